FILE: rtl/afrd_pkg.sv
// Shared types and constants for the API frame receive deframer.
package afrd_pkg;

    localparam logic [7:0] START_DELIM   = 8'h7E;
    localparam logic [7:0] CHECKSUM_GOOD = 8'hFF;
    localparam logic [7:0] TYPE_TX_STAT  = 8'h88;
    localparam logic [7:0] TYPE_RCMD_RSP = 8'h97;
    localparam logic [7:0] TYPE_TX_DONE  = 8'h8B;
    localparam logic [7:0] TYPE_RX_PKT   = 8'h90;

    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_BAD_SUM  = 3'd1;
    localparam logic [2:0] STATUS_BAD_TYPE = 3'd2;
    localparam logic [2:0] STATUS_BAD_ID   = 3'd3;
    localparam logic [2:0] STATUS_EMPTY    = 3'd4;

    localparam logic CFG_OWN_ID   = 1'b0;
    localparam logic CFG_CHECK_ID = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [7:0] frame_type;
        logic       frame_end;
        logic [2:0] frame_status;
    } result_t;

endpackage

FILE: rtl/afrd_parser.sv
// Frame parser: delimiter hunt, length, payload tracking and end-of-frame status (checksum, empty, type, id).
module afrd_parser
    import afrd_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    input  logic       step,
    input  logic [7:0] rx_byte,
    output logic       res_valid,
    output result_t    res
);

    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LEN_HI  = 3'd1;
    localparam logic [2:0] PH_LEN_LO  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [7:0]             own_id_reg;
    logic                   check_id_reg;
    logic [2:0]             phase_reg,  phase_next;
    logic [LENGTH_BITS-1:0] left_reg,   left_next;
    logic [7:0]             sum_reg,    sum_next;
    logic [7:0]             type_reg,   type_next;
    logic [7:0]             id_reg,     id_next;
    logic [1:0]             pos_reg,    pos_next;

    logic [15:0]            len_hi;
    logic [LENGTH_BITS-1:0] len_full;
    logic [LENGTH_BITS-1:0] left_dec;
    logic [7:0]             sum_add;
    logic                   type_known;
    logic                   type_resp;

    assign len_hi   = {rx_byte, 8'h00};
    assign len_full = left_reg | LENGTH_BITS'(rx_byte);
    assign left_dec = left_reg - LENGTH_BITS'(1);
    assign sum_add  = sum_reg + rx_byte;

    assign type_resp  = (type_reg == TYPE_TX_STAT) || (type_reg == TYPE_RCMD_RSP) ||
                        (type_reg == TYPE_TX_DONE);
    assign type_known = type_resp || (type_reg == TYPE_RX_PKT);

    always_comb begin
        phase_next = phase_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        type_next  = type_reg;
        id_next    = id_reg;
        pos_next   = pos_reg;
        res_valid  = 1'b0;
        res        = '0;
        unique case (phase_reg)
            PH_HUNT: begin
                if (rx_byte == START_DELIM) begin
                    phase_next = PH_LEN_HI;
                    left_next  = '0;
                    sum_next   = '0;
                    type_next  = '0;
                    id_next    = '0;
                    pos_next   = '0;
                end
            end
            PH_LEN_HI: begin
                left_next  = len_hi[LENGTH_BITS-1:0];
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                left_next  = len_full;
                phase_next = (len_full == '0) ? PH_CHECK : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                // The first payload byte is the frame type, the second the frame id.
                if (pos_reg == 2'd0) begin
                    type_next = rx_byte;
                end else if (pos_reg == 2'd1) begin
                    id_next = rx_byte;
                end
                if (pos_reg != 2'd2) begin
                    pos_next = pos_reg + 2'd1;
                end
                sum_next  = sum_add;
                left_next = left_dec;
                if (left_dec == '0) begin
                    phase_next = PH_CHECK;
                end
                res_valid          = 1'b1;
                res.data_byte      = rx_byte;
                res.frame_type     = (pos_reg == 2'd0) ? rx_byte : type_reg;
                res.frame_end      = 1'b0;
                res.frame_status   = STATUS_OK;
            end
            PH_CHECK: begin
                res_valid      = 1'b1;
                res.data_byte  = '0;
                res.frame_type = type_reg;
                res.frame_end  = 1'b1;
                if (sum_add != CHECKSUM_GOOD) begin
                    res.frame_status = STATUS_BAD_SUM;
                end else if (pos_reg == 2'd0) begin
                    res.frame_status = STATUS_EMPTY;
                end else if (!type_known) begin
                    res.frame_status = STATUS_BAD_TYPE;
                end else if (check_id_reg && type_resp && (id_reg != own_id_reg)) begin
                    res.frame_status = STATUS_BAD_ID;
                end else begin
                    res.frame_status = STATUS_OK;
                end
                phase_next = PH_HUNT;
                left_next  = '0;
                sum_next   = '0;
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg   <= 8'd1;
            check_id_reg <= 1'b1;
            phase_reg    <= PH_HUNT;
            left_reg     <= '0;
            sum_reg      <= '0;
            type_reg     <= '0;
            id_reg       <= '0;
            pos_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_OWN_ID) begin
                    own_id_reg <= cfg_wdata;
                end else begin
                    check_id_reg <= cfg_wdata[0];
                end
            end
            if (step) begin
                phase_reg <= phase_next;
                left_reg  <= left_next;
                sum_reg   <= sum_next;
                type_reg  <= type_next;
                id_reg    <= id_next;
                pos_reg   <= pos_next;
            end
        end
    end

endmodule

FILE: rtl/afrd_out_reg.sv
// Result register with valid/ready handshake toward the downstream consumer.
module afrd_out_reg
    import afrd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_data,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t m_data,
    output logic    free
);

    logic    valid_reg;
    result_t data_reg;

    // The register can take a new result when empty or when its content leaves now.
    assign free    = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (free && load) begin
            data_reg <= load_data;
        end
    end

endmodule

FILE: rtl/api_frame_receive_deframer.sv
// Top level of the API frame receive deframer: parser plus result register.
// A result request appears on the m_ side in the cycle after the byte is accepted.
// Throughput: one byte per cycle while s_ready is high; the parser updates its state in the cycle of acceptance
// and the single result register sets the pace, freed whenever m_ready is high.
// Reset: aresetn is synchronous and active low; it returns the parser to delimiter hunt,
// empties the result register and sets own_frame_id to 1 and check_frame_id to 1.
module api_frame_receive_deframer
    import afrd_pkg::*;
#(
    parameter int LENGTH_BITS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Configuration write port: index 0 is own_frame_id, index 1 is check_frame_id.
    input  logic       cfg_wr_en,
    input  logic       cfg_index,
    input  logic [7:0] cfg_wdata,
    // Incoming serial bytes.
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    // Payload bytes and end-of-frame status.
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [7:0] m_frame_type,
    output logic       m_frame_end,
    output logic [2:0] m_frame_status
);

    logic    step;
    logic    res_valid;
    result_t res;
    logic    out_free;
    result_t out_data;

    // A byte is taken whenever the result register can absorb whatever it produces.
    // Bytes that give no result (hunting, length) still need a free slot, which keeps
    // the accept condition independent of the byte value.
    assign s_ready = out_free;
    assign step    = s_valid && s_ready;

    afrd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .rx_byte   (s_rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    // The result register holds one finished request while the next byte is parsed.
    afrd_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (step && res_valid),
        .load_data (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (out_data),
        .free      (out_free)
    );

    assign m_data_byte    = out_data.data_byte;
    assign m_frame_type   = out_data.frame_type;
    assign m_frame_end    = out_data.frame_end;
    assign m_frame_status = out_data.frame_status;

endmodule
